/* design/pat_pkg.sv */
// shared types, constants and lookup functions for the packet airtime calculator
// no dependencies; used by pat_symbols and packet_airtime_calc
package pat_pkg;

  localparam int SfW    = 4;
  localparam int CodeW  = 4;
  localparam int LenW   = 16;
  localparam int TimeW  = 27;
  localparam int SumW   = 18;
  localparam int NumW   = 17;
  localparam int DivW   = 4;
  localparam int RecW   = 18;
  localparam int RecShr = 20;
  localparam int ProdW  = NumW + RecW;
  localparam int BlkW   = 15;
  localparam int RemW   = 5;
  localparam int TW     = 19;
  localparam int MulW   = 3;
  localparam int ShrW   = 3;
  localparam int TaW    = TW + MulW;
  localparam int YW     = 32;
  localparam int Rec2W  = 29;
  localparam int Prod2W = YW + Rec2W;
  localparam int Q2W    = 29;
  localparam int DvW    = 7;
  localparam int Rem2W  = 8;

  localparam logic [SfW-1:0]   SF_MIN   = 4'd7;
  localparam logic [SfW-1:0]   SF_MAX   = 4'd12;
  localparam logic [CodeW-1:0] CODE_MAX = 4'd9;

  // odd part of the scaled bandwidth divisor
  typedef enum logic [1:0] {
    DIV_13,
    DIV_39,
    DIV_125
  } dsel_t;

  typedef struct packed {
    logic             v;
    logic             ok;
    logic [SfW-1:0]   sf;
    logic [CodeW-1:0] code;
  } tag_t;

  // time = floor(t * mul * 2^(sf - shr) / div)
  typedef struct packed {
    logic [MulW-1:0] mul;
    logic [ShrW-1:0] shr;
    dsel_t           dsel;
  } bw_cfg_t;

  // floor(2^20 / d) for symbol block divisor d = sf - 2
  function automatic logic [RecW-1:0] sym_recip(input logic [DivW-1:0] d);
    logic [RecW-1:0] m;
    case (d)
      4'd5:    m = 18'd209715;
      4'd6:    m = 18'd174762;
      4'd7:    m = 18'd149796;
      4'd8:    m = 18'd131072;
      4'd9:    m = 18'd116508;
      4'd10:   m = 18'd104857;
      default: m = 18'd209715;
    endcase
    return m;
  endfunction

  // 500 / bw_hz reduced: 7800 -> 5/78, 31250 -> 2/125, 62500 -> 1/125, ...
  function automatic bw_cfg_t bw_cfg(input logic [CodeW-1:0] code);
    bw_cfg_t c;
    case (code)
      4'd0:    c = '{mul: 3'd5, shr: 3'd1, dsel: DIV_39};
      4'd1:    c = '{mul: 3'd5, shr: 3'd3, dsel: DIV_13};
      4'd2:    c = '{mul: 3'd5, shr: 3'd2, dsel: DIV_39};
      4'd3:    c = '{mul: 3'd5, shr: 3'd4, dsel: DIV_13};
      4'd4:    c = '{mul: 3'd2, shr: 3'd0, dsel: DIV_125};
      4'd5:    c = '{mul: 3'd5, shr: 3'd5, dsel: DIV_13};
      4'd6:    c = '{mul: 3'd1, shr: 3'd0, dsel: DIV_125};
      4'd7:    c = '{mul: 3'd1, shr: 3'd1, dsel: DIV_125};
      4'd8:    c = '{mul: 3'd1, shr: 3'd2, dsel: DIV_125};
      4'd9:    c = '{mul: 3'd1, shr: 3'd3, dsel: DIV_125};
      default: c = '{mul: 3'd1, shr: 3'd0, dsel: DIV_125};
    endcase
    return c;
  endfunction

  function automatic logic [DvW-1:0] div_value(input dsel_t s);
    logic [DvW-1:0] v;
    case (s)
      DIV_13:  v = 7'd13;
      DIV_39:  v = 7'd39;
      DIV_125: v = 7'd125;
      default: v = 7'd125;
    endcase
    return v;
  endfunction

  // floor(2^32 / div)
  function automatic logic [Rec2W-1:0] div_recip(input dsel_t s);
    logic [Rec2W-1:0] m;
    case (s)
      DIV_13:  m = 29'd330382099;
      DIV_39:  m = 29'd110127366;
      DIV_125: m = 29'd34359738;
      default: m = 29'd34359738;
    endcase
    return m;
  endfunction

endpackage

/* design/pat_symbols.sv */
// four-stage front end: payload symbol count and the time numerator 2*symbols+25
// depends on pat_pkg
module pat_symbols (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [pat_pkg::SfW-1:0]    in_sf,
  input  logic [pat_pkg::CodeW-1:0]  in_code,
  input  logic [pat_pkg::LenW-1:0]   in_len,
  output pat_pkg::tag_t              tag_o,
  output logic [pat_pkg::TW-1:0]     t_o
);

  pat_pkg::tag_t s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  pat_pkg::tag_t s1_tag_nxt;

  logic [pat_pkg::NumW-1:0]  s1_n_r, s2_n_r;
  logic [pat_pkg::DivW-1:0]  s1_d_r, s2_d_r, s3_d_r;
  logic [pat_pkg::ProdW-1:0] s2_prod_r;
  logic [pat_pkg::BlkW-1:0]  s3_q_r;
  logic [pat_pkg::RemW-1:0]  s3_rem_r;
  logic [pat_pkg::TW-1:0]    s4_t_r;

  logic [pat_pkg::SumW-1:0]  sum;
  logic [pat_pkg::SumW-1:0]  sf_ext;
  logic [pat_pkg::NumW-1:0]  s1_n_nxt;
  logic [pat_pkg::DivW-1:0]  s1_d_nxt;
  logic [pat_pkg::ProdW-1:0] s2_prod_nxt;
  logic [pat_pkg::BlkW-1:0]  s3_q_nxt;
  logic [pat_pkg::NumW-1:0]  s3_qd;
  logic [pat_pkg::NumW-1:0]  s3_diff;
  logic [pat_pkg::RemW-1:0]  s3_rem_nxt;
  logic [pat_pkg::RemW-1:0]  rem_adj;
  logic [pat_pkg::BlkW-1:0]  q_adj;
  logic [pat_pkg::BlkW-1:0]  blocks;
  logic [pat_pkg::TW-1:0]    s4_t_nxt;

  // stage 1: blocks dividend (2*len + 6 - sf), clamped at zero
  always_comb begin
    sum    = {1'b0, in_len, 1'b0} + 18'd6;
    sf_ext = {{(pat_pkg::SumW - pat_pkg::SfW){1'b0}}, in_sf};
    if (sum > sf_ext) begin
      s1_n_nxt = pat_pkg::NumW'(sum - sf_ext);
    end else begin
      s1_n_nxt = '0;
    end
    s1_d_nxt        = in_sf - 4'd2;
    s1_tag_nxt.v    = in_valid;
    s1_tag_nxt.ok   = (in_code <= pat_pkg::CODE_MAX) && (in_sf >= pat_pkg::SF_MIN) &&
                      (in_sf <= pat_pkg::SF_MAX);
    s1_tag_nxt.sf   = in_sf;
    s1_tag_nxt.code = in_code;
  end

  // stage 2: reciprocal multiply
  assign s2_prod_nxt = pat_pkg::ProdW'(s1_n_r) * pat_pkg::ProdW'(pat_pkg::sym_recip(s1_d_r));

  // stage 3: estimate is low by at most one
  always_comb begin
    s3_q_nxt   = s2_prod_r[pat_pkg::RecShr +: pat_pkg::BlkW];
    s3_qd      = pat_pkg::NumW'(s3_q_nxt) * pat_pkg::NumW'(s2_d_r);
    s3_diff    = s2_n_r - s3_qd;
    s3_rem_nxt = s3_diff[pat_pkg::RemW-1:0];
  end

  // stage 4: correct, round up, t = 2*(5*blocks + 8) + 25
  always_comb begin
    if (s3_rem_r >= {1'b0, s3_d_r}) begin
      rem_adj = s3_rem_r - {1'b0, s3_d_r};
      q_adj   = s3_q_r + 15'd1;
    end else begin
      rem_adj = s3_rem_r;
      q_adj   = s3_q_r;
    end
    blocks   = q_adj + {14'd0, (rem_adj != '0)};
    s4_t_nxt = pat_pkg::TW'(blocks) * 19'd10 + 19'd41;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.v <= 1'b0;
      s2_tag_r.v <= 1'b0;
      s3_tag_r.v <= 1'b0;
      s4_tag_r.v <= 1'b0;
    end else if (en) begin
      s1_tag_r <= s1_tag_nxt;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_n_r    <= s1_n_nxt;
      s1_d_r    <= s1_d_nxt;
      s2_n_r    <= s1_n_r;
      s2_d_r    <= s1_d_r;
      s2_prod_r <= s2_prod_nxt;
      s3_d_r    <= s2_d_r;
      s3_q_r    <= s3_q_nxt;
      s3_rem_r  <= s3_rem_nxt;
      s4_t_r    <= s4_t_nxt;
    end
  end

  assign tag_o = s4_tag_r;
  assign t_o   = s4_t_r;

endmodule

/* design/packet_airtime_calc.sv */
// top level of the packet airtime calculator: symbol front end plus time scaling
// depends on pat_pkg and pat_symbols
//
// usage: one request on the in_ channel (spreading factor, bandwidth code,
// payload length in bytes) gives exactly one result on the out_ channel:
// on-air time in whole milliseconds and a legality flag. an illegal
// spreading factor (outside 7..12) or bandwidth code (above 9) returns
// valid_res low with a time of 0; a legal request never reports less than 1 ms.
// the datapath is an 8-stage pipeline (two reciprocal multiplies, each
// followed by a compare-and-correct stage), the last stage being the output
// register; one request is taken every cycle while the pipeline is not stalled.
// all stages advance together on one enable; in_ready is low only while a
// result sits in the output register and out_ready is low, so a stall
// freezes the whole pipeline and nothing is lost or repeated.
// a synchronous reset (rst_n low) clears all stage valid bits; no clearing
// pass, the block takes requests in the first cycle after reset.
module packet_airtime_calc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pat_pkg::SfW-1:0]     in_spread_factor,
  input  logic [pat_pkg::CodeW-1:0]   in_bandwidth_code,
  input  logic [pat_pkg::LenW-1:0]    in_payload_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pat_pkg::TimeW-1:0]   out_air_time_ms,
  output logic                        out_valid_res
);

  logic en;

  pat_pkg::tag_t           sym_tag;
  logic [pat_pkg::TW-1:0]  sym_t;

  pat_pkg::tag_t s5_tag_r, s6_tag_r, s7_tag_r, out_tag_r;

  logic [pat_pkg::YW-1:0]     s5_y_r, s6_y_r;
  pat_pkg::dsel_t             s5_dsel_r, s6_dsel_r, s7_dsel_r;
  logic [pat_pkg::Prod2W-1:0] s6_prod_r;
  logic [pat_pkg::Q2W-1:0]    s7_q_r;
  logic [pat_pkg::Rem2W-1:0]  s7_rem_r;
  logic [pat_pkg::TimeW-1:0]  out_time_r;

  pat_pkg::bw_cfg_t           cfg;
  logic [pat_pkg::SfW-1:0]    sh;
  logic [pat_pkg::TaW-1:0]    ta;
  logic [pat_pkg::YW-1:0]     s5_y_nxt;
  logic [pat_pkg::Prod2W-1:0] s6_prod_nxt;
  logic [pat_pkg::Q2W-1:0]    s7_q_nxt;
  logic [pat_pkg::YW-1:0]     s7_qd;
  logic [pat_pkg::YW-1:0]     s7_diff;
  logic [pat_pkg::Q2W-1:0]    q_fin;
  logic [pat_pkg::TimeW-1:0]  out_time_nxt;

  assign en       = !out_tag_r.v || out_ready;
  assign in_ready = en;

  pat_symbols u_symbols (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .in_sf   (in_spread_factor),
    .in_code (in_bandwidth_code),
    .in_len  (in_payload_length),
    .tag_o   (sym_tag),
    .t_o     (sym_t)
  );

  // stage 5: y = t * mul * 2^(sf - shr), below 2^32 for all legal inputs
  always_comb begin
    cfg      = pat_pkg::bw_cfg(sym_tag.code);
    sh       = sym_tag.sf - {1'b0, cfg.shr};
    ta       = pat_pkg::TaW'(sym_t) * pat_pkg::TaW'(cfg.mul);
    s5_y_nxt = pat_pkg::YW'({{(pat_pkg::YW - pat_pkg::TaW){1'b0}}, ta} << sh);
  end

  // stage 6: reciprocal multiply by the odd divisor
  assign s6_prod_nxt = pat_pkg::Prod2W'(s5_y_r) *
                       pat_pkg::Prod2W'(pat_pkg::div_recip(s5_dsel_r));

  // stage 7: quotient estimate and remainder, remainder below twice the divisor
  always_comb begin
    s7_q_nxt = s6_prod_r[pat_pkg::Prod2W-1 -: pat_pkg::Q2W];
    s7_qd    = pat_pkg::YW'(s7_q_nxt) * pat_pkg::YW'(pat_pkg::div_value(s6_dsel_r));
    s7_diff  = s6_y_r - s7_qd;
  end

  // stage 8: final correction, 1 ms floor, illegal requests forced to zero
  always_comb begin
    if (s7_rem_r >= {1'b0, pat_pkg::div_value(s7_dsel_r)}) begin
      q_fin = s7_q_r + 29'd1;
    end else begin
      q_fin = s7_q_r;
    end
    if (!s7_tag_r.ok) begin
      out_time_nxt = '0;
    end else if (q_fin == '0) begin
      out_time_nxt = 27'd1;
    end else begin
      out_time_nxt = q_fin[pat_pkg::TimeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_tag_r.v  <= 1'b0;
      s6_tag_r.v  <= 1'b0;
      s7_tag_r.v  <= 1'b0;
      out_tag_r.v <= 1'b0;
    end else if (en) begin
      s5_tag_r  <= sym_tag;
      s6_tag_r  <= s5_tag_r;
      s7_tag_r  <= s6_tag_r;
      out_tag_r <= s7_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_y_r     <= s5_y_nxt;
      s5_dsel_r  <= cfg.dsel;
      s6_y_r     <= s5_y_r;
      s6_dsel_r  <= s5_dsel_r;
      s6_prod_r  <= s6_prod_nxt;
      s7_dsel_r  <= s6_dsel_r;
      s7_q_r     <= s7_q_nxt;
      s7_rem_r   <= s7_diff[pat_pkg::Rem2W-1:0];
      out_time_r <= out_time_nxt;
    end
  end

  assign out_valid       = out_tag_r.v;
  assign out_valid_res   = out_tag_r.ok;
  assign out_air_time_ms = out_time_r;

`ifndef SYNTH
  // reciprocal estimate is never more than one low
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s7_tag_r.v && s7_tag_r.ok) |->
      ({1'b0, s7_rem_r} < {1'b0, pat_pkg::div_value(s7_dsel_r), 1'b0}))
    else $error("time remainder out of range");

  a_legal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res) |-> (out_air_time_ms != '0))
    else $error("legal request gave zero time");

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_air_time_ms == '0))
    else $error("illegal request gave nonzero time");
`endif

endmodule
